// ===== rtl/core/salcc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache counter.
// Used by the cache counter top level; has no dependencies of its own.
package salcc_pkg;

  // Default sizes of the line store.
  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS     = 8;

  // Stored field widths.
  localparam int TAG_W   = 64;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;

  // Configuration register widths.
  localparam int SB_W = 4;
  localparam int BB_W = 6;
  localparam int WU_W = 4;

  // Register indexes on the configuration port (word addresses).
  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SB_W-1:0] SET_BITS_RST    = 4'd4;
  localparam logic [BB_W-1:0] BLOCK_BITS_RST  = 6'd4;
  localparam logic [WU_W-1:0] WAYS_IN_USE_RST = 4'd1;

  // Access kinds.
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_STORE  = 2'd1;
  localparam logic [1:0] FUNC_MODIFY = 2'd2;

  // Result of one access.
  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_COMMIT
  } state_e;

endpackage

// ===== rtl/core/set_assoc_lru_cache_counter.sv =====
// Top level of the set-associative LRU cache hit/miss counter.
// Depends on salcc_pkg and on the generic RAM salcc_ram, which holds one set per row.
//
// Usage: each request on the input channel (func_i, address_i) is one memory
// access. The address is split into set and tag by the set_bits and block_bits
// registers, the set row is read from the line RAM, and one result leaves on the
// output channel: hit, fill of an empty way or eviction of the least recently
// used way, the hits counted, and the saturating running totals.
// Timing: a request is taken in IDLE and its set row read in that cycle; the next
// cycle looks at the row. A hit or a fill writes the row back and loads the
// output register there, or from COMMIT once the output register is free; the next
// request can be taken in the cycle after. An eviction first scans the stamps one
// way per cycle over the ways in use (ways_in_use clamped to 1..MaxWays) and then
// writes back the least recently used way.
// Only one request is in flight, so a row is always written back before the
// next read of the line RAM.
// Stall: the output register holds a result until it is taken; a new request is
// accepted meanwhile, and its write-back waits until the output register is free.
// Reset: counters and flags clear, then a clearing pass writes every set row,
// and no request is accepted during that pass. Configuration
// writes are taken at any time and do not clear the lines.
module set_assoc_lru_cache_counter
  import salcc_pkg::*;
#(
  parameter int MaxSetBits = MAX_SET_BITS,
  parameter int MaxWays    = MAX_WAYS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Access requests
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] address_i,
  // Results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  outcome_o,
  output logic [1:0]  hits_added_o,
  output logic [31:0] hit_total_o,
  output logic [31:0] miss_total_o,
  output logic [31:0] eviction_total_o,
  output logic        stamp_wrapped_o
);

  localparam int Sets = 2 ** MaxSetBits;
  localparam int SetW = MaxSetBits;
  localparam int WayW = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int CntW = $clog2(MaxWays + 1);
  localparam int RowW = MaxWays * (1 + TAG_W + STAMP_W);

  // Configuration registers.
  logic [SB_W-1:0] set_bits_q;
  logic [BB_W-1:0] block_bits_q;
  logic [WU_W-1:0] ways_in_use_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= SET_BITS_RST;
      block_bits_q  <= BLOCK_BITS_RST;
      ways_in_use_q <= WAYS_IN_USE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SET_BITS:    set_bits_q    <= pwdata[SB_W-1:0];
        REG_BLOCK_BITS:  block_bits_q  <= pwdata[BB_W-1:0];
        REG_WAYS_IN_USE: ways_in_use_q <= pwdata[WU_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_SET_BITS:    prdata = {{(32-SB_W){1'b0}}, set_bits_q};
      REG_BLOCK_BITS:  prdata = {{(32-BB_W){1'b0}}, block_bits_q};
      REG_WAYS_IN_USE: prdata = {{(32-WU_W){1'b0}}, ways_in_use_q};
      default:         prdata = '0;
    endcase
  end

  // Effective set bits and ways, clamped to the store's size.
  logic [SB_W-1:0] sb_eff;
  logic [4:0]      wu_ext;
  logic [CntW-1:0] ways_eff;

  always_comb begin
    sb_eff = (set_bits_q > SB_W'(MaxSetBits)) ? SB_W'(MaxSetBits) : set_bits_q;
    wu_ext = {1'b0, ways_in_use_q};
    if (wu_ext == 5'd0) begin
      ways_eff = CntW'(1);
    end else if (wu_ext > 5'(MaxWays)) begin
      ways_eff = CntW'(MaxWays);
    end else begin
      ways_eff = CntW'(wu_ext);
    end
  end

  // Address split for the incoming request.
  logic [6:0]       split_total;
  logic [63:0]      addr_shift;
  logic [SetW-1:0]  set_mask;
  logic [SetW-1:0]  set_idx;
  logic [TAG_W-1:0] tag_in;

  always_comb begin
    split_total = {3'b000, sb_eff} + {1'b0, block_bits_q};
    addr_shift  = address_i >> block_bits_q;
    set_mask    = ~({SetW{1'b1}} << sb_eff);
    set_idx     = addr_shift[SetW-1:0] & set_mask;
    tag_in      = (split_total >= 7'd64) ? '0 : (address_i >> split_total[5:0]);
  end

  // Control state.
  state_e          state_q, state_d;
  logic [SetW-1:0] clr_q, clr_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [WayW-1:0] victim_q, victim_d;

  // Request payload held while the set is processed.
  logic [TAG_W-1:0] tag_q;
  logic [SetW-1:0]  set_q;
  logic [1:0]       func_q;
  logic [WayW-1:0]  way_q;
  outcome_e         outc_q;

  // Line RAM, one row per set.
  logic                                 ram_we;
  logic [SetW-1:0]                      ram_waddr;
  logic [RowW-1:0]                      ram_wdata;
  logic [RowW-1:0]                      ram_rdata;
  logic [MaxWays-1:0]                   row_valid;
  logic [MaxWays-1:0][TAG_W-1:0]        row_tag;
  logic [MaxWays-1:0][STAMP_W-1:0]      row_stamp;
  logic [MaxWays-1:0]                   wr_valid;
  logic [MaxWays-1:0][TAG_W-1:0]        wr_tag;
  logic [MaxWays-1:0][STAMP_W-1:0]      wr_stamp;

  assign {row_stamp, row_tag, row_valid} = ram_rdata;

  logic accept;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  salcc_ram #(
    .Width (RowW),
    .Depth (Sets)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (set_idx),
    .rdata_o (ram_rdata)
  );

  // Tag search and first empty way; the lowest way wins.
  logic            hit_any, empty_any;
  logic [WayW-1:0] hit_way, empty_way;

  always_comb begin
    hit_any   = 1'b0;
    empty_any = 1'b0;
    hit_way   = '0;
    empty_way = '0;
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if (CntW'(w) < ways_eff) begin
        if (row_valid[w] && (row_tag[w] == tag_q)) begin
          hit_any = 1'b1;
          hit_way = WayW'(w);
        end
        if (!row_valid[w]) begin
          empty_any = 1'b1;
          empty_way = WayW'(w);
        end
      end
    end
  end

  // Counters, stamp and the output register.
  logic [STAMP_W-1:0] stamp_q;
  logic [CNT_W-1:0]   hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic               wrap_q;
  logic               out_valid_q;
  logic               out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Commit selection and next-state logic.
  logic            commit_req, commit_fire;
  logic [WayW-1:0] commit_way;
  outcome_e        commit_outc;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    victim_d    = victim_q;
    commit_req  = 1'b0;
    commit_way  = way_q;
    commit_outc = outc_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (hit_any) begin
          commit_req  = 1'b1;
          commit_way  = hit_way;
          commit_outc = OUT_HIT;
        end else if (empty_any) begin
          commit_req  = 1'b1;
          commit_way  = empty_way;
          commit_outc = OUT_FILL;
        end else begin
          state_d  = ST_SCAN;
          scan_d   = CntW'(1);
          victim_d = '0;
        end
      end
      ST_SCAN: begin
        // One stamp compare per cycle; strict less keeps the lowest way on ties.
        if (scan_q < ways_eff) begin
          if (row_stamp[scan_q[WayW-1:0]] < row_stamp[victim_q]) begin
            victim_d = scan_q[WayW-1:0];
          end
          scan_d = scan_q + 1'b1;
        end else begin
          commit_req  = 1'b1;
          commit_way  = victim_q;
          commit_outc = OUT_EVICT;
        end
      end
      ST_COMMIT: begin
        commit_req = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
    commit_fire = commit_req && out_free;
    if (commit_fire) begin
      state_d = ST_IDLE;
    end else if (commit_req) begin
      state_d = ST_COMMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      scan_q   <= '0;
      victim_q <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      scan_q   <= scan_d;
      victim_q <= victim_d;
    end
  end

  // Request payload and the chosen way.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q  <= tag_in;
      set_q  <= set_idx;
      func_q <= func_i;
    end
    if (commit_req) begin
      way_q  <= commit_way;
      outc_q <= commit_outc;
    end
  end

  // Update values for one committed access.
  logic               is_modify;
  logic [1:0]         added;
  logic [STAMP_W-1:0] stamp_next;
  logic [CNT_W:0]     hit_sum;
  logic [CNT_W-1:0]   hit_cnt_d, miss_cnt_d, evict_cnt_d;
  logic               wrap_d;

  always_comb begin
    is_modify  = (func_q == FUNC_MODIFY);
    if (commit_outc == OUT_HIT) begin
      added = is_modify ? 2'd2 : 2'd1;
    end else begin
      added = is_modify ? 2'd1 : 2'd0;
    end
    stamp_next = stamp_q + 1'b1;
    wrap_d     = wrap_q || (stamp_next == '0);
    hit_sum    = {1'b0, hit_cnt_q} + (CNT_W + 1)'(added);
    hit_cnt_d  = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
    miss_cnt_d = miss_cnt_q;
    if ((commit_outc != OUT_HIT) && !(&miss_cnt_q)) begin
      miss_cnt_d = miss_cnt_q + 1'b1;
    end
    evict_cnt_d = evict_cnt_q;
    if ((commit_outc == OUT_EVICT) && !(&evict_cnt_q)) begin
      evict_cnt_d = evict_cnt_q + 1'b1;
    end
  end

  // Row write-back: mark valid, store tag, refresh stamp; the clearing pass writes zero rows.
  always_comb begin
    wr_valid             = row_valid;
    wr_tag               = row_tag;
    wr_stamp             = row_stamp;
    wr_valid[commit_way] = 1'b1;
    wr_tag[commit_way]   = tag_q;
    wr_stamp[commit_way] = stamp_next;
    ram_we               = (state_q == ST_CLEAR) || commit_fire;
    ram_waddr            = (state_q == ST_CLEAR) ? clr_q : set_q;
    ram_wdata            = (state_q == ST_CLEAR) ? '0 : {wr_stamp, wr_tag, wr_valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q     <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit_fire) begin
        stamp_q     <= stamp_next;
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        evict_cnt_q <= evict_cnt_d;
        wrap_q      <= wrap_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (commit_fire) begin
      outcome_o        <= commit_outc;
      hits_added_o     <= added;
      hit_total_o      <= hit_cnt_d;
      miss_total_o     <= miss_cnt_d;
      eviction_total_o <= evict_cnt_d;
      stamp_wrapped_o  <= wrap_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/salcc_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// The read data is registered and holds while no read is enabled. No dependencies.
module salcc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== verif/salcc_tb_pkg.sv =====
// Scoreboard for the set-associative LRU cache counter testbench: a cache image that
// predicts each access and a queue of expected results. Depends on salcc_pkg.
package salcc_tb_pkg;
  import salcc_pkg::*;

  localparam int LINE_COUNT = (1 << MAX_SET_BITS) * MAX_WAYS;

  // One result as it leaves the block.
  typedef struct packed {
    outcome_e         outcome;
    logic [1:0]       hits_added;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
    logic             stamp_wrapped;
  } access_result_t;

  class lru_scoreboard;
    logic [SB_W-1:0]    set_bits;
    logic [BB_W-1:0]    block_bits;
    logic [WU_W-1:0]    ways_in_use;
    bit                 line_valid [LINE_COUNT];
    logic [TAG_W-1:0]   line_tag   [LINE_COUNT];
    logic [STAMP_W-1:0] line_stamp [LINE_COUNT];
    logic [STAMP_W-1:0] stamp_counter;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   misses;
    logic [CNT_W-1:0]   evictions;
    logic               wrapped;
    access_result_t     expected_results [$];
    int unsigned        mismatches;

    function new();
      set_bits      = SET_BITS_RST;
      block_bits    = BLOCK_BITS_RST;
      ways_in_use   = WAYS_IN_USE_RST;
      foreach (line_valid[i]) line_valid[i] = 1'b0;
      stamp_counter = '0;
      hits          = '0;
      misses        = '0;
      evictions     = '0;
      wrapped       = 1'b0;
      mismatches    = 0;
    endfunction

    // Register writes follow the configuration port; the lines are kept as they are.
    function void write_register(logic [1:0] index, logic [31:0] value);
      case (index)
        REG_SET_BITS:    set_bits    = value[SB_W-1:0];
        REG_BLOCK_BITS:  block_bits  = value[BB_W-1:0];
        REG_WAYS_IN_USE: ways_in_use = value[WU_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CNT_W-1:0] saturating_inc(logic [CNT_W-1:0] count, int unsigned step);
      logic [CNT_W:0] sum;
      sum = count + step;
      return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    endfunction

    // Every access takes the next stamp; a wrap to zero sets the sticky flag.
    function logic [STAMP_W-1:0] advance_stamp();
      stamp_counter = stamp_counter + 1'b1;
      if (stamp_counter == '0) wrapped = 1'b1;
      return stamp_counter;
    endfunction

    // Work out the result of one accepted request and update the cache image.
    function void note_access(logic [1:0] func, logic [63:0] address);
      int unsigned      sb;
      int unsigned      ways;
      int unsigned      total;
      int unsigned      set_idx;
      int unsigned      base;
      int unsigned      victim;
      logic [TAG_W-1:0] tag;
      bit               hit;
      bit               found_empty;
      access_result_t   res;
      // Out-of-range settings are clamped; a split of 64 bits or more leaves no tag.
      sb      = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : set_bits;
      ways    = (ways_in_use == 0) ? 1 : ((ways_in_use > MAX_WAYS) ? MAX_WAYS : ways_in_use);
      total   = sb + block_bits;
      tag     = (total >= TAG_W) ? '0 : (address >> total);
      set_idx = 32'((address >> block_bits) & ((64'd1 << sb) - 64'd1));
      base    = set_idx * MAX_WAYS;
      hit         = 1'b0;
      found_empty = 1'b0;
      victim      = 0;

      // The first valid way with a matching tag is a hit and gets a fresh stamp.
      for (int w = 0; w < ways; w++) begin
        if (!hit && line_valid[base + w] && line_tag[base + w] == tag) begin
          line_stamp[base + w] = advance_stamp();
          hit = 1'b1;
        end
      end

      if (hit) begin
        res.outcome    = OUT_HIT;
        res.hits_added = (func == FUNC_MODIFY) ? 2'd2 : 2'd1;
      end else begin
        // Fill the first empty way, else evict the oldest stamp, lowest way on a tie.
        for (int w = 0; w < ways; w++) begin
          if (!found_empty && !line_valid[base + w]) begin
            victim      = w;
            found_empty = 1'b1;
          end
        end
        if (found_empty) begin
          res.outcome = OUT_FILL;
        end else begin
          for (int w = 1; w < ways; w++) begin
            if (line_stamp[base + w] < line_stamp[base + victim]) victim = w;
          end
          evictions   = saturating_inc(evictions, 1);
          res.outcome = OUT_EVICT;
        end
        misses                  = saturating_inc(misses, 1);
        line_valid[base + victim] = 1'b1;
        line_tag[base + victim]   = tag;
        line_stamp[base + victim] = advance_stamp();
        res.hits_added          = (func == FUNC_MODIFY) ? 2'd1 : 2'd0;
      end

      hits               = saturating_inc(hits, res.hits_added);
      res.hit_total      = hits;
      res.miss_total     = misses;
      res.eviction_total = evictions;
      res.stamp_wrapped  = wrapped;
      expected_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
      end
    endtask

    // Compare one result with the oldest expectation, field by field.
    task check_access(access_result_t got);
      access_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        compare_field("outcome", got.outcome, want.outcome);
        compare_field("hits_added", got.hits_added, want.hits_added);
        compare_field("hit_total", got.hit_total, want.hit_total);
        compare_field("miss_total", got.miss_total, want.miss_total);
        compare_field("eviction_total", got.eviction_total, want.eviction_total);
        compare_field("stamp_wrapped", got.stamp_wrapped, want.stamp_wrapped);
      end
    endtask
  endclass

endpackage

// ===== verif/tb_set_assoc_lru_cache_counter.sv =====
// Top-level testbench of set_assoc_lru_cache_counter: directed and random accesses under
// many register settings, random idling on both channels. Depends on salcc_tb_pkg.
module tb_set_assoc_lru_cache_counter
  import salcc_pkg::*;
  import salcc_tb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNDEF = 2'd3;
  localparam int IDLE_PCT       = 27;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_ITEMS    = 48;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [63:0] address_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  outcome_o;
  logic [1:0]  hits_added_o;
  logic [31:0] hit_total_o;
  logic [31:0] miss_total_o;
  logic [31:0] eviction_total_o;
  logic        stamp_wrapped_o;

  lru_scoreboard board;
  bit            steady_flow;
  int unsigned   quiet_cycles = 0;

  set_assoc_lru_cache_counter uut (.*);

  // 20 ns clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Offer one request after a random gap and wait until it is taken.
  task automatic send_access(logic [1:0] func, logic [63:0] address);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    address_i  <= address;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_access(func, address);
  endtask

  // Stop offering requests and wait until every result has been taken.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register is written when pready is seen.
  task automatic apb_write(logic [1:0] index, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.write_register(index, value);
  endtask

  task automatic configure(logic [SB_W-1:0] sb, logic [BB_W-1:0] bb, logic [WU_W-1:0] wu);
    apb_write(REG_SET_BITS, 32'(sb));
    apb_write(REG_BLOCK_BITS, 32'(bb));
    apb_write(REG_WAYS_IN_USE, 32'(wu));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly accesses to one to three sets with up to three more tags than ways, so hits,
  // fills and evictions can all occur; the rest are fully random addresses.
  task automatic run_random_phase(logic [SB_W-1:0] sb, logic [BB_W-1:0] bb,
                                  logic [WU_W-1:0] wu, int unsigned count);
    int unsigned sb_eff;
    int unsigned ways_eff;
    int unsigned total;
    int unsigned ntags;
    int unsigned nsets;
    int unsigned set_base;
    int unsigned set_idx;
    logic [63:0] tag_base;
    logic [63:0] tag;
    logic [63:0] addr;
    configure(sb, bb, wu);
    sb_eff   = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
    ways_eff = (wu == 0) ? 1 : ((wu > MAX_WAYS) ? MAX_WAYS : wu);
    total    = sb_eff + bb;
    ntags    = ways_eff + $urandom_range(0, 3);
    nsets    = $urandom_range(1, 3);
    set_base = $urandom;
    tag_base = random_word();
    repeat (count) begin
      if ($urandom_range(0, 99) < 85) begin
        tag     = tag_base + $urandom_range(0, ntags - 1);
        set_idx = set_base + $urandom_range(0, nsets - 1);
        addr    = (total >= 64) ? 64'd0 : (tag << total);
        addr    = addr | ((64'(set_idx) & ((64'd1 << sb_eff) - 64'd1)) << bb);
        addr    = addr | (random_word() & ((64'd1 << bb) - 64'd1));
      end else begin
        addr = random_word();
      end
      send_access(2'($urandom_range(0, 3)), addr);
    end
    wait_idle();
  endtask

  // Result side: random stalls, and every result taken is checked.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_access(access_result_t'{outcome_e'(outcome_o), hits_added_o, hit_total_o,
                                          miss_total_o, eviction_total_o, stamp_wrapped_o});
    end
    out_ready_i <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Count cycles in which no request and no result moves.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    board       = new();
    steady_flow = 1'b0;
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    func_i      <= FUNC_LOAD;
    address_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, one way per set: fill, hit, modify hit, top address,
    // undefined access kind acting as a load, eviction on a modify.
    send_access(FUNC_LOAD, 64'h0);
    send_access(FUNC_LOAD, 64'h0);
    send_access(FUNC_MODIFY, 64'h8);
    send_access(FUNC_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(FUNC_UNDEF, 64'h100);
    send_access(FUNC_MODIFY, 64'h0);
    wait_idle();

    // No set bits gives a single set; zero ways acts as one. Old lines stay.
    configure(4'd0, 6'd1, 4'd0);
    send_access(FUNC_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(FUNC_LOAD, 64'h1);
    send_access(FUNC_STORE, 64'h0);
    wait_idle();

    // Set and ways above their maximum, and a split past 64 bits leaving no tag.
    configure(4'd15, 6'd60, 4'd15);
    send_access(FUNC_LOAD, 64'h8000_0000_0000_0000);
    send_access(FUNC_LOAD, 64'hF000_0000_0000_0000);
    send_access(FUNC_MODIFY, 64'h8123_4567_89AB_CDEF);
    send_access(FUNC_STORE, 64'h0);
    wait_idle();

    // All eight ways of one set: fill, then least-recently-used eviction.
    configure(4'd8, 6'd32, 4'd8);
    for (int k = 1; k <= 9; k++) send_access(FUNC_LOAD, 64'(k) << 40);
    send_access(FUNC_MODIFY, 64'd3 << 40);
    send_access(FUNC_LOAD, 64'd1 << 40);
    wait_idle();

    // Random traffic under extreme and random settings.
    run_random_phase(4'd1, 6'd63, 4'd8, PHASE_ITEMS);
    run_random_phase(4'd8, 6'd0, 4'd15, PHASE_ITEMS);
    run_random_phase(4'd15, 6'd32, 4'd0, PHASE_ITEMS);
    steady_flow = 1'b1;
    run_random_phase(4'd2, 6'd5, 4'd4, 2 * PHASE_ITEMS);
    steady_flow = 1'b0;
    repeat (5) begin
      run_random_phase(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                       4'($urandom_range(0, 15)), PHASE_ITEMS);
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
